// ===== hw/rtl/kld_pkg.sv =====
// Package for the histogram KL divergence block: widths, constants,
// datapath command codes and the controller/datapath status bundle.
// No dependencies.
package kld_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int TOT_W       = SAMPLE_BITS + ADDR_W;
    localparam int FRAC_BITS   = 30;
    localparam int M_W         = FRAC_BITS + 1;
    localparam int EXP_W       = $clog2(TOT_W);
    localparam int LOG_W       = EXP_W + FRAC_BITS;
    localparam int W_FRAC      = 24;
    localparam int W_W         = W_FRAC + 1;
    localparam int SPLIT       = 18;
    localparam int PA_W        = SPLIT + W_W;
    localparam int PB_W        = LOG_W - SPLIT + W_W;
    localparam int SUM_W       = LOG_W + W_W;
    localparam int TERM_W      = SUM_W - W_FRAC;
    localparam int ACC_W       = TERM_W + ADDR_W + 2;
    localparam int OUT_SHIFT   = FRAC_BITS - 16;
    localparam int SH_W        = ACC_W - OUT_SHIFT;
    localparam int DIV_W       = 32;
    localparam int PAIR_W      = 2 * SAMPLE_BITS;

    localparam logic [W_W-1:0]   LN2_Q24 = W_W'(11629080);
    localparam logic [DIV_W-1:0] DIV_MAX = 32'h7fff_ffff;
    localparam logic [DIV_W-1:0] DIV_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TLOG,
        OP_SAVE,
        OP_PSTART,
        OP_DIFF,
        OP_MAG,
        OP_MUL_LN,
        OP_SUM_LN,
        OP_MUL_W,
        OP_SUM_W,
        OP_ACC,
        OP_SKIP,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic zero_sum;
        logic idx_end;
        logic both_nz;
        logic busy;
    } t_stat;

endpackage

// ===== hw/rtl/kld_in_if.sv =====
// Input channel of the KL divergence block: one sample pair per transfer.
// Depends on kld_pkg.
interface kld_in_if;
    logic                             valid;
    logic                             ready;
    logic [kld_pkg::SAMPLE_BITS-1:0]  p_value;
    logic [kld_pkg::SAMPLE_BITS-1:0]  q_value;
    logic                             last_point;

    modport source(output valid, p_value, q_value, last_point, input ready);
    modport sink(input valid, p_value, q_value, last_point, output ready);
endinterface

// ===== hw/rtl/kld_out_if.sv =====
// Output channel of the KL divergence block: one result per set.
// Depends on kld_pkg.
interface kld_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [kld_pkg::DIV_W-1:0]  divergence;
    logic [kld_pkg::CNT_W-1:0]         invalid_points;
    logic                              zero_sum_error;

    modport source(output valid, divergence, invalid_points, zero_sum_error, input ready);
    modport sink(input valid, divergence, invalid_points, zero_sum_error, output ready);
endinterface

// ===== hw/rtl/kld_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module kld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/kld_log2.sv =====
// Iterative fixed-point log2 unit: normalize, then one squaring per cycle.
// Depends on kld_pkg.
module kld_log2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [kld_pkg::TOT_W-1:0]  i_x,
    output logic                       o_busy,
    output logic [kld_pkg::LOG_W-1:0]  o_log
);
    typedef enum logic [1:0] {S_IDLE, S_NORM, S_SQ} t_state;

    t_state                          r_state;
    logic [kld_pkg::M_W-1:0]         r_m;
    logic [kld_pkg::EXP_W-1:0]       r_shift;
    logic [kld_pkg::EXP_W-1:0]       r_cnt;
    logic [kld_pkg::FRAC_BITS-1:0]   r_frac;
    logic [2*kld_pkg::M_W-1:0]       sq;
    logic [kld_pkg::M_W:0]           t;

    assign sq = r_m * r_m;
    assign t  = sq[kld_pkg::FRAC_BITS +: kld_pkg::M_W + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m     <= kld_pkg::M_W'(i_x);
                        r_shift <= '0;
                        r_frac  <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_m[kld_pkg::M_W-1] || r_m == '0) begin
                        r_cnt   <= kld_pkg::EXP_W'(kld_pkg::FRAC_BITS - 1);
                        r_state <= S_SQ;
                    end else if (r_m[kld_pkg::M_W-1 -: 4] == '0) begin
                        r_m     <= r_m << 4;
                        r_shift <= r_shift + kld_pkg::EXP_W'(4);
                    end else begin
                        r_m     <= r_m << 1;
                        r_shift <= r_shift + kld_pkg::EXP_W'(1);
                    end
                end
                S_SQ: begin
                    if (t[kld_pkg::M_W]) begin
                        r_m <= t[kld_pkg::M_W:1];
                    end else begin
                        r_m <= t[kld_pkg::M_W-1:0];
                    end
                    r_frac <= {r_frac[kld_pkg::FRAC_BITS-2:0], t[kld_pkg::M_W]};
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - kld_pkg::EXP_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_log  = {kld_pkg::EXP_W'(kld_pkg::FRAC_BITS) - r_shift, r_frac};

    a_norm_mantissa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQ |-> r_m[kld_pkg::M_W-1])
        else $error("log2 mantissa left [1,2)");
endmodule

// ===== hw/rtl/kld_datapath.sv =====
// Datapath: sample store, running totals, log and divide units,
// product stages, accumulator and result registers.
// Depends on kld_pkg, kld_ram, kld_log2.
module kld_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kld_pkg::t_cmd                    i_cmd,
    input  logic [kld_pkg::SAMPLE_BITS-1:0]  i_p_value,
    input  logic [kld_pkg::SAMPLE_BITS-1:0]  i_q_value,
    output kld_pkg::t_stat                   o_stat,
    output logic signed [kld_pkg::DIV_W-1:0] o_divergence,
    output logic [kld_pkg::CNT_W-1:0]        o_invalid_points,
    output logic                             o_zero_sum_error
);
    logic [kld_pkg::TOT_W-1:0]       r_p_total, r_q_total;
    logic [kld_pkg::CNT_W-1:0]       r_count, r_idx, r_invalid;
    logic [kld_pkg::LOG_W-1:0]       r_lsp, r_lsq, r_mag, r_lnmag;
    logic [kld_pkg::LOG_W:0]         r_up, r_dn;
    logic                            r_neg;
    logic [kld_pkg::PA_W-1:0]        r_pa;
    logic [kld_pkg::PB_W-1:0]        r_pb;
    logic [kld_pkg::TERM_W-1:0]      r_term;
    logic signed [kld_pkg::ACC_W-1:0] r_acc;
    logic [kld_pkg::TOT_W:0]         r_rem;
    logic [kld_pkg::W_W-1:0]         r_quo;
    logic [kld_pkg::EXP_W-1:0]       r_dcnt;
    logic                            r_dbusy;
    logic signed [kld_pkg::DIV_W-1:0] r_div;
    logic [kld_pkg::CNT_W-1:0]       r_inv_out;
    logic                            r_err;

    logic                            full, zero_sum, we;
    logic [kld_pkg::ADDR_W-1:0]      addr;
    logic [kld_pkg::PAIR_W-1:0]      rdata;
    logic [kld_pkg::SAMPLE_BITS-1:0] p_rd, q_rd;
    logic                            start_t, start_p, busy_a, busy_b;
    logic [kld_pkg::TOT_W-1:0]       x_a, x_b;
    logic [kld_pkg::LOG_W-1:0]       log_a, log_b;
    logic                            ge;
    logic [kld_pkg::TOT_W:0]         rr;
    logic [kld_pkg::LOG_W-1:0]       mul_a;
    logic [kld_pkg::W_W-1:0]         mul_b;
    logic [kld_pkg::SUM_W-1:0]       psum;
    logic [kld_pkg::ACC_W-1:0]       acc_mag;
    logic [kld_pkg::SH_W-1:0]        sh;
    logic [kld_pkg::DIV_W-1:0]       div_val;

    assign full     = (r_count == kld_pkg::CNT_W'(kld_pkg::MAX_POINTS));
    assign zero_sum = (r_p_total == '0) || (r_q_total == '0);
    assign we       = (i_cmd.op == kld_pkg::OP_LOAD) && !full;
    assign addr     = (i_cmd.op == kld_pkg::OP_LOAD) ? r_count[kld_pkg::ADDR_W-1:0]
                                                     : r_idx[kld_pkg::ADDR_W-1:0];

    kld_ram #(.WIDTH(kld_pkg::PAIR_W), .DEPTH(kld_pkg::MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata ({i_p_value, i_q_value}),
        .o_rdata (rdata)
    );

    assign p_rd = rdata[kld_pkg::PAIR_W-1 -: kld_pkg::SAMPLE_BITS];
    assign q_rd = rdata[kld_pkg::SAMPLE_BITS-1:0];

    assign start_t = (i_cmd.op == kld_pkg::OP_TLOG);
    assign start_p = (i_cmd.op == kld_pkg::OP_PSTART);
    assign x_a     = start_t ? r_p_total : kld_pkg::TOT_W'(p_rd);
    assign x_b     = start_t ? r_q_total : kld_pkg::TOT_W'(q_rd);

    kld_log2 u_log_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_t || start_p),
        .i_x     (x_a),
        .o_busy  (busy_a),
        .o_log   (log_a)
    );

    kld_log2 u_log_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_t || start_p),
        .i_x     (x_b),
        .o_busy  (busy_b),
        .o_log   (log_b)
    );

    assign ge = (r_rem >= {1'b0, r_p_total});
    assign rr = ge ? (r_rem - {1'b0, r_p_total}) : r_rem;

    assign mul_a = (i_cmd.op == kld_pkg::OP_MUL_LN) ? r_mag : r_lnmag;
    assign mul_b = (i_cmd.op == kld_pkg::OP_MUL_LN) ? kld_pkg::LN2_Q24 : r_quo;
    assign psum  = {r_pb, kld_pkg::SPLIT'(0)} + kld_pkg::SUM_W'(r_pa);

    assign acc_mag = r_acc[kld_pkg::ACC_W-1] ? kld_pkg::ACC_W'(-r_acc)
                                             : kld_pkg::ACC_W'(r_acc);
    assign sh      = acc_mag[kld_pkg::ACC_W-1:kld_pkg::OUT_SHIFT];

    always_comb begin
        if (r_acc[kld_pkg::ACC_W-1]) begin
            if (sh > kld_pkg::SH_W'(kld_pkg::DIV_MIN)) begin
                div_val = kld_pkg::DIV_MIN;
            end else begin
                div_val = ~sh[kld_pkg::DIV_W-1:0] + kld_pkg::DIV_W'(1);
            end
        end else begin
            if (sh > kld_pkg::SH_W'(kld_pkg::DIV_MAX)) begin
                div_val = kld_pkg::DIV_MAX;
            end else begin
                div_val = sh[kld_pkg::DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_total <= '0;
            r_q_total <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_invalid <= '0;
            r_dbusy   <= 1'b0;
        end else begin
            if (r_dbusy) begin
                r_quo <= {r_quo[kld_pkg::W_W-2:0], ge};
                r_rem <= {rr[kld_pkg::TOT_W-1:0], 1'b0};
                if (r_dcnt == '0) begin
                    r_dbusy <= 1'b0;
                end else begin
                    r_dcnt <= r_dcnt - kld_pkg::EXP_W'(1);
                end
            end
            case (i_cmd.op)
                kld_pkg::OP_LOAD: begin
                    if (!full) begin
                        r_p_total <= r_p_total + kld_pkg::TOT_W'(i_p_value);
                        r_q_total <= r_q_total + kld_pkg::TOT_W'(i_q_value);
                        r_count   <= r_count + kld_pkg::CNT_W'(1);
                    end
                end
                kld_pkg::OP_TLOG: begin
                    r_acc     <= '0;
                    r_invalid <= '0;
                    r_idx     <= '0;
                end
                kld_pkg::OP_SAVE: begin
                    r_lsp <= log_a;
                    r_lsq <= log_b;
                end
                kld_pkg::OP_PSTART: begin
                    r_rem   <= (kld_pkg::TOT_W + 1)'(p_rd);
                    r_quo   <= '0;
                    r_dcnt  <= kld_pkg::EXP_W'(kld_pkg::W_W - 1);
                    r_dbusy <= 1'b1;
                end
                kld_pkg::OP_DIFF: begin
                    r_up <= {1'b0, log_a} + {1'b0, r_lsq};
                    r_dn <= {1'b0, log_b} + {1'b0, r_lsp};
                end
                kld_pkg::OP_MAG: begin
                    r_neg <= (r_dn > r_up);
                    r_mag <= (r_dn > r_up) ? kld_pkg::LOG_W'(r_dn - r_up)
                                           : kld_pkg::LOG_W'(r_up - r_dn);
                end
                kld_pkg::OP_MUL_LN, kld_pkg::OP_MUL_W: begin
                    r_pa <= mul_a[kld_pkg::SPLIT-1:0] * mul_b;
                    r_pb <= mul_a[kld_pkg::LOG_W-1:kld_pkg::SPLIT] * mul_b;
                end
                kld_pkg::OP_SUM_LN: begin
                    r_lnmag <= psum[kld_pkg::W_FRAC +: kld_pkg::LOG_W];
                end
                kld_pkg::OP_SUM_W: begin
                    r_term <= psum[kld_pkg::W_FRAC +: kld_pkg::TERM_W];
                end
                kld_pkg::OP_ACC: begin
                    if (r_neg) begin
                        r_acc <= r_acc - kld_pkg::ACC_W'(r_term);
                    end else begin
                        r_acc <= r_acc + kld_pkg::ACC_W'(r_term);
                    end
                    r_idx <= r_idx + kld_pkg::CNT_W'(1);
                end
                kld_pkg::OP_SKIP: begin
                    if ((p_rd == '0) != (q_rd == '0)) begin
                        r_invalid <= r_invalid + kld_pkg::CNT_W'(1);
                    end
                    r_idx <= r_idx + kld_pkg::CNT_W'(1);
                end
                kld_pkg::OP_RESULT: begin
                    r_div     <= zero_sum ? '0 : div_val;
                    r_inv_out <= zero_sum ? '0 : r_invalid;
                    r_err     <= zero_sum;
                    r_p_total <= '0;
                    r_q_total <= '0;
                    r_count   <= '0;
                    r_idx     <= '0;
                    r_invalid <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.zero_sum = zero_sum;
    assign o_stat.idx_end  = (r_idx == r_count);
    assign o_stat.both_nz  = (p_rd != '0) && (q_rd != '0);
    assign o_stat.busy     = busy_a || busy_b || r_dbusy;

    assign o_divergence     = r_div;
    assign o_invalid_points = r_inv_out;
    assign o_zero_sum_error = r_err;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("pass index beyond stored count");
endmodule

// ===== hw/rtl/kld_ctrl.sv =====
// Controller: accepts pairs, sequences the final pass over the store,
// and drives the result transfer.
// Depends on kld_pkg.
module kld_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_last_point,
    input  logic            i_out_ready,
    input  kld_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output kld_pkg::t_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_TLOG, S_READ, S_WAITRD, S_PWAIT, S_MAG,
        S_MLN, S_SLN, S_MW, S_SW, S_ACC, S_RESULT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.op = kld_pkg::OP_NONE;
        case (r_state)
            S_IDLE:   o_cmd.op = i_in_valid ? kld_pkg::OP_LOAD : kld_pkg::OP_NONE;
            S_CHECK:  o_cmd.op = i_stat.zero_sum ? kld_pkg::OP_NONE : kld_pkg::OP_TLOG;
            S_TLOG:   o_cmd.op = i_stat.busy ? kld_pkg::OP_NONE : kld_pkg::OP_SAVE;
            S_WAITRD: o_cmd.op = i_stat.both_nz ? kld_pkg::OP_PSTART : kld_pkg::OP_SKIP;
            S_PWAIT:  o_cmd.op = i_stat.busy ? kld_pkg::OP_NONE : kld_pkg::OP_DIFF;
            S_MAG:    o_cmd.op = kld_pkg::OP_MAG;
            S_MLN:    o_cmd.op = kld_pkg::OP_MUL_LN;
            S_SLN:    o_cmd.op = kld_pkg::OP_SUM_LN;
            S_MW:     o_cmd.op = kld_pkg::OP_MUL_W;
            S_SW:     o_cmd.op = kld_pkg::OP_SUM_W;
            S_ACC:    o_cmd.op = kld_pkg::OP_ACC;
            S_RESULT: o_cmd.op = out_free ? kld_pkg::OP_RESULT : kld_pkg::OP_NONE;
            default:  o_cmd.op = kld_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_last_point) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK:  r_state <= i_stat.zero_sum ? S_RESULT : S_TLOG;
                S_TLOG: begin
                    if (!i_stat.busy) begin
                        r_state <= S_READ;
                    end
                end
                S_READ:   r_state <= i_stat.idx_end ? S_RESULT : S_WAITRD;
                S_WAITRD: r_state <= i_stat.both_nz ? S_PWAIT : S_READ;
                S_PWAIT: begin
                    if (!i_stat.busy) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG:    r_state <= S_MLN;
                S_MLN:    r_state <= S_SLN;
                S_SLN:    r_state <= S_MW;
                S_MW:     r_state <= S_SW;
                S_SW:     r_state <= S_ACC;
                S_ACC:    r_state <= S_READ;
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == kld_pkg::OP_PSTART |=> i_stat.busy)
        else $error("units did not start");
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == kld_pkg::OP_RESULT |=> o_out_valid)
        else $error("result loaded without valid");
    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && i_stat.idx_end) |=> r_state == S_RESULT)
        else $error("pass did not end at stored count");
endmodule

// ===== hw/rtl/kl_divergence_of_histograms.sv =====
// Load takes one sample pair per cycle; pairs beyond 1024 are dropped, and
// a last mark still closes the set. After the last pair the block stops taking
// input for the final pass: log2 of both totals first, then per stored point a
// skip if either sample is zero, otherwise a step paced by the two log2 units
// (normalize steps plus 30 squaring steps, each one 31x31 multiply) that run
// beside a 25-step divider. The result register then holds one result per set
// until transferred; the next set loads while it waits.
module kl_divergence_of_histograms (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kld_in_if.sink     i_in,
    kld_out_if.source  o_out
);
    kld_pkg::t_cmd  cmd;
    kld_pkg::t_stat stat;

    kld_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_last_point (i_in.last_point),
        .i_out_ready  (o_out.ready),
        .i_stat       (stat),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .o_cmd        (cmd)
    );

    kld_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_p_value        (i_in.p_value),
        .i_q_value        (i_in.q_value),
        .o_stat           (stat),
        .o_divergence     (o_out.divergence),
        .o_invalid_points (o_out.invalid_points),
        .o_zero_sum_error (o_out.zero_sum_error)
    );
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for kl_divergence_of_histograms: random and directed sample sets,
// with a scoreboard class that predicts each set's divergence result.
// Depends on kld_pkg, kld_in_if, kld_out_if and kl_divergence_of_histograms.
module testbench;

    typedef struct {
        logic signed [kld_pkg::DIV_W-1:0] divergence;
        logic [kld_pkg::CNT_W-1:0]        invalid_points;
        logic                             zero_sum_error;
    } t_kld_result;

    class kld_scoreboard;
        logic [kld_pkg::SAMPLE_BITS-1:0] p_hist[kld_pkg::MAX_POINTS];
        logic [kld_pkg::SAMPLE_BITS-1:0] q_hist[kld_pkg::MAX_POINTS];
        longint unsigned        p_sum;
        longint unsigned        q_sum;
        int                     n_points;
        t_kld_result            expected_q[$];
        int                     mismatches;
        int                     sets_done;

        function new();
            p_sum = 0;
            q_sum = 0;
            n_points = 0;
            mismatches = 0;
            sets_done = 0;
        endfunction

        function longint unsigned log2_fix(longint unsigned x);
            int              e;
            longint unsigned m;
            longint unsigned frac;
            longint unsigned t;
            e = 0;
            frac = 0;
            t = x;
            while (t > 1) begin
                t = t >> 1;
                e++;
            end
            if (e >= kld_pkg::FRAC_BITS) m = x >> (e - kld_pkg::FRAC_BITS);
            else m = x << (kld_pkg::FRAC_BITS - e);
            for (int i = kld_pkg::FRAC_BITS - 1; i >= 0; i--) begin
                m = (m * m) >> kld_pkg::FRAC_BITS;
                if (m >= (64'd2 << kld_pkg::FRAC_BITS)) begin
                    m = m >> 1;
                    frac |= 64'd1 << i;
                end
            end
            return (longint'(e) << kld_pkg::FRAC_BITS) | frac;
        endfunction

        function void note_input(logic [kld_pkg::SAMPLE_BITS-1:0] p,
                                 logic [kld_pkg::SAMPLE_BITS-1:0] q, logic last);
            longint          acc;
            longint          div;
            longint unsigned lsp, lsq, up, dn, mag, lnmag, w, term;
            int              bad;
            logic            zs;
            t_kld_result     r;
            acc = 0;
            bad = 0;
            if (n_points < kld_pkg::MAX_POINTS) begin
                p_hist[n_points] = p;
                q_hist[n_points] = q;
                p_sum += p;
                q_sum += q;
                n_points++;
            end
            if (!last) return;
            zs = (p_sum == 0) || (q_sum == 0);
            if (!zs) begin
                lsp = log2_fix(p_sum);
                lsq = log2_fix(q_sum);
                for (int i = 0; i < n_points; i++) begin
                    if (p_hist[i] != 0 && q_hist[i] != 0) begin
                        up = log2_fix(p_hist[i]) + lsq;
                        dn = log2_fix(q_hist[i]) + lsp;
                        mag = (dn > up) ? dn - up : up - dn;
                        lnmag = (mag * 64'd11629080) >> 24;
                        w = (longint'(p_hist[i]) << 24) / p_sum;
                        term = (lnmag * w) >> 24;
                        if (dn > up) acc -= longint'(term);
                        else acc += longint'(term);
                    end else if ((p_hist[i] == 0) != (q_hist[i] == 0)) begin
                        bad++;
                    end
                end
            end
            if (acc < 0) div = -longint'(longint'(-acc) >>> kld_pkg::OUT_SHIFT);
            else div = acc >>> kld_pkg::OUT_SHIFT;
            if (div > 64'sd2147483647) div = 64'sd2147483647;
            if (div < -64'sd2147483648) div = -64'sd2147483648;
            r.divergence = div[31:0];
            r.invalid_points = zs ? '0 : kld_pkg::CNT_W'(bad);
            r.zero_sum_error = zs;
            expected_q.push_back(r);
            p_sum = 0;
            q_sum = 0;
            n_points = 0;
        endfunction

        function void check_result(logic signed [kld_pkg::DIV_W-1:0] d,
                                   logic [kld_pkg::CNT_W-1:0] inv, logic zs);
            t_kld_result r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: div=%0d inv=%0d zs=%0b", d, inv, zs);
                return;
            end
            r = expected_q.pop_front();
            sets_done++;
            if (d !== r.divergence || inv !== r.invalid_points ||
                zs !== r.zero_sum_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp div=%0d inv=%0d zs=%0b, got div=%0d inv=%0d zs=%0b",
                             r.divergence, r.invalid_points, r.zero_sum_error, d, inv, zs);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle;
    int   snk_stall;
    int   quiet_cycles;
    int   items_sent;
    kld_scoreboard board;

    kld_in_if  in_ch();
    kld_out_if out_ch();

    kl_divergence_of_histograms dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 300000) begin
            $display("stalled after %0d pairs and %0d checked sets", items_sent,
                     board.sets_done);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.divergence, out_ch.invalid_points,
                               out_ch.zero_sum_error);
        out_ch.ready <= ($urandom_range(0, 99) >= snk_stall);
    end

    task automatic send_pair(logic [kld_pkg::SAMPLE_BITS-1:0] p,
                             logic [kld_pkg::SAMPLE_BITS-1:0] q, logic last);
        while ($urandom_range(0, 99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.p_value    <= p;
        in_ch.q_value    <= q;
        in_ch.last_point <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(p, q, last);
        items_sent++;
    endtask

    function automatic logic [kld_pkg::SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 25) return '1;
        if (r < 45) return kld_pkg::SAMPLE_BITS'($urandom_range(1, 16));
        return kld_pkg::SAMPLE_BITS'($urandom);
    endfunction

    task automatic send_set(int n);
        for (int i = 0; i < n; i++)
            send_pair(pick_sample(), pick_sample(), i == n - 1);
    endtask

    initial begin
        board = new();
        src_idle = 0;
        snk_stall = 0;
        quiet_cycles = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.p_value = '0;
        in_ch.q_value = '0;
        in_ch.last_point = 1'b0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(16'd0, 16'd0, 1'b1);
        send_pair(16'hffff, 16'hffff, 1'b1);
        send_pair(16'd0, 16'd5, 1'b0);
        send_pair(16'd5, 16'd0, 1'b0);
        send_pair(16'd0, 16'd0, 1'b0);
        send_pair(16'd3, 16'd3, 1'b1);
        send_pair(16'hffff, 16'd1, 1'b0);
        send_pair(16'd1, 16'hffff, 1'b1);
        send_pair(16'd0, 16'd7, 1'b0);
        send_pair(16'd0, 16'd9, 1'b1);
        send_pair(16'd4, 16'd0, 1'b0);
        send_pair(16'd8, 16'd0, 1'b1);
        send_pair(16'haaaa, 16'h5555, 1'b0);
        send_pair(16'h5555, 16'haaaa, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 55; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 55; end
                default: begin src_idle = 20; snk_stall = 20; end
            endcase
            if (ph == 2) send_set(kld_pkg::MAX_POINTS + 3);
            while (items_sent < 14 + (ph + 1) * 110 +
                   (ph >= 2 ? kld_pkg::MAX_POINTS + 3 : 0))
                send_set($urandom_range(1, 12));
        end
        in_ch.valid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d pairs in %0d sets, including an overfull store and zero sums",
                 items_sent, board.sets_done);
        if (board.mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
